// ===== hdl/lhs_pkg.sv =====
`timescale 1ns / 1ps

package lhs_pkg;

  // Blacklist depth and the time that one tick stands for.
  localparam int LIST_DEPTH  = 8;
  localparam int MS_PER_TICK = 1000;

  // Field widths.
  localparam int ADDR_W    = 48;
  localparam int TYPE_W    = 2;
  localparam int MS_W      = 22;
  localparam int CNT_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 48;
  localparam int COUNT_W   = 4;

  // Fill count holds 0..LIST_DEPTH; an entry index holds 0..LIST_DEPTH-1.
  localparam int FILL_W = $clog2(LIST_DEPTH + 1);
  localparam int IDX_W  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  // Grace period after a scan before its results are judged.
  localparam int SCAN_GRACE_MS = 500;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_SCAN   = 2'd1,
    MODE_CONN   = 2'd2,
    MODE_LISTEN = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CMD_NONE    = 2'd0,
    CMD_SCAN    = 2'd1,
    CMD_CONNECT = 2'd2,
    CMD_DROP    = 2'd3
  } link_cmd_t;

  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_LOOKUP  = 2'd1,
    REQ_CLEAR   = 2'd2,
    REQ_SESSION = 2'd3
  } req_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_ENABLE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_VALID    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ADDR     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_TYPE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_TIME       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CONNECT_TIMEOUT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_TIMEOUT = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_WAIT      = 3'd7;

  // Reset values of the timing registers.
  localparam logic [MS_W-1:0] SCAN_TIME_RST       = 22'd10000;
  localparam logic [MS_W-1:0] CONNECT_TIMEOUT_RST = 22'd12000;
  localparam logic [MS_W-1:0] SILENCE_TIMEOUT_RST = 22'd45000;
  localparam logic [MS_W-1:0] RETRY_WAIT_RST      = 22'd5000;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic time_calc;
    logic eval;
    logic search_step;
    logic commit;
  } lhs_ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic search_done;
    logic search_hit;
  } lhs_stat_t;

endpackage

// ===== hdl/link_hunt_supervisor_top.sv =====
`timescale 1ns / 1ps

// Connection-hunting supervisor. Each input transaction is a tick, a blacklist
// lookup, a blacklist clear or a session note, and it yields exactly one result
// transaction carrying the command for the link layer, the mode after the
// request and the running counters. One transaction is processed at a time: it
// passes through time update, decision, blacklist walk and commit. The walk ends
// at once when no walk is needed and otherwise stops at a match or after the
// last stored entry; one stored address is read from the blacklist memory per
// cycle. The result sits in an output register, so the next transaction is
// accepted while it waits to be taken; only a result that is still unclaimed
// when the following one is ready holds the block up. Configuration writes take
// effect at once and must only be issued while no transaction is outstanding.
// The blacklist memory is not cleared at reset; only entries below the fill
// count are ever read.

module link_hunt_supervisor_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [lhs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lhs_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    req_type,
  input  logic                          link_up,
  input  logic                          notify_seen,
  input  logic                          peer_valid,
  input  logic [lhs_pkg::ADDR_W-1:0]    peer_addr,
  input  logic                          cand_valid,
  input  logic [lhs_pkg::ADDR_W-1:0]    cand_addr,
  input  logic [lhs_pkg::TYPE_W-1:0]    cand_type,
  input  logic                          start_ok,
  input  logic [lhs_pkg::ADDR_W-1:0]    query_addr,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    command,
  output logic [lhs_pkg::ADDR_W-1:0]    conn_addr,
  output logic [lhs_pkg::TYPE_W-1:0]    conn_type,
  output logic [1:0]                    mode_now,
  output logic                          is_blocked,
  output logic [lhs_pkg::COUNT_W-1:0]   blocked_count,
  output logic [lhs_pkg::CNT_W-1:0]     attempt_total,
  output logic [lhs_pkg::CNT_W-1:0]     session_total
);

  import lhs_pkg::*;

  // Command strobes from the sequencer and status back from the datapath.
  lhs_ctl_t  ctl;
  lhs_stat_t stat;

  // The sequencer owns the handshakes and steps each transaction through
  // time update, decision, blacklist walk and commit.
  lhs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  // The datapath holds the configuration, the mode and its timer, the
  // blacklist memory, the counters and the result register.
  lhs_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .req_type      (req_type),
    .link_up       (link_up),
    .notify_seen   (notify_seen),
    .peer_valid    (peer_valid),
    .peer_addr     (peer_addr),
    .cand_valid    (cand_valid),
    .cand_addr     (cand_addr),
    .cand_type     (cand_type),
    .start_ok      (start_ok),
    .query_addr    (query_addr),
    .ctl           (ctl),
    .stat          (stat),
    .command       (command),
    .conn_addr     (conn_addr),
    .conn_type     (conn_type),
    .mode_now      (mode_now),
    .is_blocked    (is_blocked),
    .blocked_count (blocked_count),
    .attempt_total (attempt_total),
    .session_total (session_total)
  );

endmodule

// ===== hdl/lhs_datapath.sv =====
`timescale 1ns / 1ps

module lhs_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [lhs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lhs_pkg::CFG_W-1:0]        cfg_data,
  input  logic [1:0]                       req_type,
  input  logic                             link_up,
  input  logic                             notify_seen,
  input  logic                             peer_valid,
  input  logic [lhs_pkg::ADDR_W-1:0]       peer_addr,
  input  logic                             cand_valid,
  input  logic [lhs_pkg::ADDR_W-1:0]       cand_addr,
  input  logic [lhs_pkg::TYPE_W-1:0]       cand_type,
  input  logic                             start_ok,
  input  logic [lhs_pkg::ADDR_W-1:0]       query_addr,
  input  lhs_pkg::lhs_ctl_t                ctl,
  output lhs_pkg::lhs_stat_t               stat,
  output logic [1:0]                       command,
  output logic [lhs_pkg::ADDR_W-1:0]       conn_addr,
  output logic [lhs_pkg::TYPE_W-1:0]       conn_type,
  output logic [1:0]                       mode_now,
  output logic                             is_blocked,
  output logic [lhs_pkg::COUNT_W-1:0]      blocked_count,
  output logic [lhs_pkg::CNT_W-1:0]        attempt_total,
  output logic [lhs_pkg::CNT_W-1:0]        session_total
);

  import lhs_pkg::*;

  // Configuration registers.
  logic              auto_enable;
  logic              target_valid;
  logic [ADDR_W-1:0] target_addr;
  logic [TYPE_W-1:0] target_type;
  logic [MS_W-1:0]   scan_time_ms;
  logic [MS_W-1:0]   connect_timeout_ms;
  logic [MS_W-1:0]   silence_timeout_ms;
  logic [MS_W-1:0]   retry_wait_ms;

  // Architectural state.
  mode_t             mode;
  logic [CNT_W-1:0]  time_in_mode;
  logic [FILL_W-1:0] fill;
  logic [CNT_W-1:0]  attempts;
  logic [CNT_W-1:0]  sessions;
  logic [ADDR_W-1:0] block_list [LIST_DEPTH];

  // Captured transaction.
  req_t              r_req;
  logic              r_link_up;
  logic              r_notify;
  logic              r_peer_valid;
  logic [ADDR_W-1:0] r_peer_addr;
  logic              r_cand_valid;
  logic [ADDR_W-1:0] r_cand_addr;
  logic [TYPE_W-1:0] r_cand_type;
  logic              r_start_ok;
  logic [ADDR_W-1:0] r_query_addr;

  // Advanced mode time.
  logic [CNT_W:0]    t_sum;
  logic [CNT_W-1:0]  t_sat;

  // Decision, combinational and registered.
  link_cmd_t         e_cmd;
  logic [ADDR_W-1:0] e_addr;
  logic [TYPE_W-1:0] e_type;
  mode_t             e_mode;
  logic [CNT_W-1:0]  e_time;
  logic              e_att;
  logic              e_ins;
  logic [MS_W:0]     scan_limit;

  link_cmd_t         dec_cmd;
  logic [ADDR_W-1:0] dec_addr;
  logic [TYPE_W-1:0] dec_type;
  mode_t             dec_mode;
  logic [CNT_W-1:0]  dec_time;
  logic              dec_att;
  logic              dec_ins;

  // Blacklist walk.
  logic [FILL_W-1:0] idx;
  logic              rd_pend;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_data;
  logic [ADDR_W-1:0] key;
  logic              need_search;
  logic              hit;

  // Commit values.
  logic              ins_ok;
  logic [FILL_W-1:0] fill_next;
  logic [CNT_W-1:0]  attempts_next;
  logic [CNT_W-1:0]  sessions_next;

  assign t_sum      = {1'b0, time_in_mode} + (CNT_W + 1)'(MS_PER_TICK);
  assign scan_limit = {1'b0, scan_time_ms} + (MS_W + 1)'(SCAN_GRACE_MS);

  always_comb begin
    e_cmd  = CMD_NONE;
    e_addr = '0;
    e_type = '0;
    e_mode = mode;
    e_time = time_in_mode;
    e_att  = 1'b0;
    e_ins  = 1'b0;
    if (r_req == REQ_TICK) begin
      e_time = t_sat;
      if (auto_enable) begin
        if (r_link_up) begin
          // Only a peer already being listened to can have gone silent.
          if ((mode == MODE_LISTEN) && !r_notify &&
              (t_sat > CNT_W'(silence_timeout_ms))) begin
            e_cmd  = CMD_DROP;
            e_ins  = r_peer_valid;
            e_mode = MODE_IDLE;
            e_time = '0;
          end else begin
            e_mode = MODE_LISTEN;
            if (mode != MODE_LISTEN) begin
              e_time = '0;
            end
          end
        end else begin
          case (mode)
            MODE_IDLE: begin
              if (t_sat >= CNT_W'(retry_wait_ms)) begin
                e_att = 1'b1;
                if (target_valid) begin
                  e_cmd  = CMD_CONNECT;
                  e_addr = target_addr;
                  e_type = target_type;
                  if (r_start_ok) begin
                    e_mode = MODE_CONN;
                    e_time = '0;
                  end
                end else begin
                  e_cmd = CMD_SCAN;
                  if (r_start_ok) begin
                    e_mode = MODE_SCAN;
                    e_time = '0;
                  end
                end
              end
            end
            MODE_SCAN: begin
              if (t_sat >= CNT_W'(scan_limit)) begin
                if (r_cand_valid) begin
                  e_cmd  = CMD_CONNECT;
                  e_addr = r_cand_addr;
                  e_type = r_cand_type;
                end
                e_mode = (r_cand_valid && r_start_ok) ? MODE_CONN : MODE_IDLE;
                e_time = '0;
              end
            end
            MODE_CONN: begin
              if (t_sat > CNT_W'(connect_timeout_ms)) begin
                e_cmd  = CMD_DROP;
                e_mode = MODE_IDLE;
                e_time = '0;
              end
            end
            default: begin
              e_mode = MODE_IDLE;
              e_time = '0;
            end
          endcase
        end
      end
    end
  end

  assign rd_en = ctl.search_step && need_search && !hit && (idx < fill);

  assign stat.search_done = !need_search || hit || ((idx >= fill) && !rd_pend);
  assign stat.search_hit  = hit;

  assign ins_ok        = dec_ins && !hit && (fill < FILL_W'(LIST_DEPTH));
  assign attempts_next = attempts + CNT_W'(dec_att);
  assign sessions_next = sessions + CNT_W'(r_req == REQ_SESSION);

  always_comb begin
    fill_next = fill;
    if (r_req == REQ_CLEAR) begin
      fill_next = '0;
    end else if (ins_ok) begin
      fill_next = fill + FILL_W'(1);
    end
  end

  // Configuration and architectural state.
  always_ff @(posedge clk) begin
    if (rst) begin
      auto_enable        <= 1'b0;
      target_valid       <= 1'b0;
      target_addr        <= '0;
      target_type        <= '0;
      scan_time_ms       <= SCAN_TIME_RST;
      connect_timeout_ms <= CONNECT_TIMEOUT_RST;
      silence_timeout_ms <= SILENCE_TIMEOUT_RST;
      retry_wait_ms      <= RETRY_WAIT_RST;
      mode               <= MODE_IDLE;
      time_in_mode       <= '0;
      fill               <= '0;
      attempts           <= '0;
      sessions           <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_AUTO_ENABLE: begin
            auto_enable <= cfg_data[0];
            if (!cfg_data[0]) begin
              mode         <= MODE_IDLE;
              time_in_mode <= '0;
            end
          end
          CFG_TARGET_VALID:    target_valid       <= cfg_data[0];
          CFG_TARGET_ADDR:     target_addr        <= cfg_data[ADDR_W-1:0];
          CFG_TARGET_TYPE:     target_type        <= cfg_data[TYPE_W-1:0];
          CFG_SCAN_TIME:       scan_time_ms       <= cfg_data[MS_W-1:0];
          CFG_CONNECT_TIMEOUT: connect_timeout_ms <= cfg_data[MS_W-1:0];
          CFG_SILENCE_TIMEOUT: silence_timeout_ms <= cfg_data[MS_W-1:0];
          CFG_RETRY_WAIT:      retry_wait_ms      <= cfg_data[MS_W-1:0];
          default: ;
        endcase
      end
      if (ctl.commit) begin
        mode         <= dec_mode;
        time_in_mode <= dec_time;
        fill         <= fill_next;
        attempts     <= attempts_next;
        sessions     <= sessions_next;
      end
    end
  end

  // Captured fields, mode time and the registered decision.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      r_req        <= req_t'(req_type);
      r_link_up    <= link_up;
      r_notify     <= notify_seen;
      r_peer_valid <= peer_valid;
      r_peer_addr  <= peer_addr;
      r_cand_valid <= cand_valid;
      r_cand_addr  <= cand_addr;
      r_cand_type  <= cand_type;
      r_start_ok   <= start_ok;
      r_query_addr <= query_addr;
    end
    if (ctl.time_calc) begin
      t_sat <= t_sum[CNT_W] ? {CNT_W{1'b1}} : t_sum[CNT_W-1:0];
    end
    if (ctl.eval) begin
      dec_cmd  <= e_cmd;
      dec_addr <= e_addr;
      dec_type <= e_type;
      dec_mode <= e_mode;
      dec_time <= e_time;
      dec_att  <= e_att;
      dec_ins  <= e_ins;
      key      <= (r_req == REQ_LOOKUP) ? r_query_addr : r_peer_addr;
    end
  end

  // Blacklist walk: one read is issued per cycle and compared in the next.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx         <= '0;
      rd_pend     <= 1'b0;
      hit         <= 1'b0;
      need_search <= 1'b0;
    end else if (ctl.eval) begin
      idx         <= '0;
      rd_pend     <= 1'b0;
      hit         <= 1'b0;
      need_search <= (r_req == REQ_LOOKUP) || e_ins;
    end else if (ctl.search_step) begin
      rd_pend <= rd_en;
      if (rd_en) begin
        idx <= idx + FILL_W'(1);
      end
      if (rd_pend && (rd_data == key)) begin
        hit <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit && ins_ok) begin
      block_list[fill[IDX_W-1:0]] <= r_peer_addr;
    end
    if (rd_en) begin
      rd_data <= block_list[idx[IDX_W-1:0]];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      command       <= dec_cmd;
      conn_addr     <= dec_addr;
      conn_type     <= dec_type;
      mode_now      <= dec_mode;
      is_blocked    <= (r_req == REQ_LOOKUP) && hit;
      blocked_count <= COUNT_W'(fill_next);
      attempt_total <= attempts_next;
      session_total <= sessions_next;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(LIST_DEPTH))
    else $error("blacklist fill count beyond depth");
`endif

endmodule

// ===== hdl/lhs_ctrl.sv =====
`timescale 1ns / 1ps

module lhs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  lhs_pkg::lhs_stat_t stat,
  output lhs_pkg::lhs_ctl_t  ctl
);

  import lhs_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_TIME   = 5'b00010,
    S_EVAL   = 5'b00100,
    S_SEARCH = 5'b01000,
    S_COMMIT = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  assign ctl.load        = in_valid && in_ready;
  assign ctl.time_calc   = (state == S_TIME);
  assign ctl.eval        = (state == S_EVAL);
  assign ctl.search_step = (state == S_SEARCH);
  assign ctl.commit      = (state == S_COMMIT) && out_free;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_valid) state_next = S_TIME;
      S_TIME:   state_next = S_EVAL;
      S_EVAL:   state_next = S_SEARCH;
      S_SEARCH: if (stat.search_done) state_next = S_COMMIT;
      S_COMMIT: if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_TIME))
    else $error("accepted transaction did not start processing");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    ctl.commit |=> (out_valid && (state == S_IDLE)))
    else $error("committed result not presented");

  a_search_ends: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SEARCH) && stat.search_hit) |=> (state == S_COMMIT))
    else $error("search continued after a match");
`endif

endmodule

// ===== tb/link_hunt_supervisor_tb.sv =====
`timescale 1ns / 1ps

// Testbench for the connection-hunting supervisor.
//
// Every request transaction that the block accepts is run through a
// behavioural copy of the supervisor held in this file. The copy keeps its own
// mode, mode timer, blacklist, counters and configuration. The report it
// produces is queued, and each result transaction that leaves the block is
// compared with the oldest queued report, all fields at once. A result with
// nothing queued, a wrong field, or a report still queued at the end is a
// failure. The run carries on to its normal end unless the watchdog stops it.
//
// The run is a set of named tests, called in turn from one initial block:
//   - requests with hunting switched off, with all fields at their extremes;
//   - the scan path: a refused start, a scan with no candidate, a refused
//     connect from scanning, a good connect and a connect timeout;
//   - listening: a notified link, silent drops with and without a known peer,
//     a duplicate blacklist entry, a lost link, lookups and a clear;
//   - a pinned target, a connect timeout at its maximum, and hunting being
//     switched off, which forces the block back to idle;
//   - a long random part in eight configuration phases, built mostly from
//     well-formed link episodes (the link comes up for a run of ticks with a
//     fixed peer) with random content, plus stray link noise.
//
// Both sides of the block wait a random gap before each transaction, except in
// two phases where they run flat out. Configuration registers are only written
// once every queued report has been matched, so the block is idle. A watchdog
// ends the run if no transaction moves for a long stretch.

module tb;

  import lhs_pkg::*;

  localparam int              STALL_LIMIT  = 2000;
  localparam int              PHASES       = 8;
  localparam int              PHASE_ITEMS  = 110;
  localparam int              POOL_SIZE    = 12;
  localparam logic [21:0]     MS_MAX       = 22'd4000000;
  localparam logic [ADDR_W-1:0] ADDR_ONES  = '1;

  // One request transaction, field by field.
  typedef struct packed {
    req_t              req;
    logic              link_up;
    logic              notify_seen;
    logic              peer_valid;
    logic [ADDR_W-1:0] peer_addr;
    logic              cand_valid;
    logic [ADDR_W-1:0] cand_addr;
    logic [TYPE_W-1:0] cand_type;
    logic              start_ok;
    logic [ADDR_W-1:0] query_addr;
  } hunt_req_t;

  // One result transaction. Plain vectors, so that X or Z from the block
  // shows up as a mismatch.
  typedef struct packed {
    logic [1:0]         cmd;
    logic [ADDR_W-1:0]  addr;
    logic [TYPE_W-1:0]  ctype;
    logic [1:0]         mode;
    logic               blocked;
    logic [COUNT_W-1:0] fill;
    logic [CNT_W-1:0]   attempts;
    logic [CNT_W-1:0]   sessions;
  } hunt_report_t;

  // Clock, reset and every input of the block, all known from time zero.
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           req_type = '0;
  logic                 link_up = 1'b0;
  logic                 notify_seen = 1'b0;
  logic                 peer_valid = 1'b0;
  logic [ADDR_W-1:0]    peer_addr = '0;
  logic                 cand_valid = 1'b0;
  logic [ADDR_W-1:0]    cand_addr = '0;
  logic [TYPE_W-1:0]    cand_type = '0;
  logic                 start_ok = 1'b0;
  logic [ADDR_W-1:0]    query_addr = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           command;
  logic [ADDR_W-1:0]    conn_addr;
  logic [TYPE_W-1:0]    conn_type;
  logic [1:0]           mode_now;
  logic                 is_blocked;
  logic [COUNT_W-1:0]   blocked_count;
  logic [CNT_W-1:0]     attempt_total;
  logic [CNT_W-1:0]     session_total;

  link_hunt_supervisor_top DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req_type      (req_type),
    .link_up       (link_up),
    .notify_seen   (notify_seen),
    .peer_valid    (peer_valid),
    .peer_addr     (peer_addr),
    .cand_valid    (cand_valid),
    .cand_addr     (cand_addr),
    .cand_type     (cand_type),
    .start_ok      (start_ok),
    .query_addr    (query_addr),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .command       (command),
    .conn_addr     (conn_addr),
    .conn_type     (conn_type),
    .mode_now      (mode_now),
    .is_blocked    (is_blocked),
    .blocked_count (blocked_count),
    .attempt_total (attempt_total),
    .session_total (session_total)
  );

  // Our own copy of the configuration registers, at their reset values.
  logic              cfg_auto = 1'b0;
  logic              cfg_target_valid = 1'b0;
  logic [ADDR_W-1:0] cfg_target_addr = '0;
  logic [TYPE_W-1:0] cfg_target_type = '0;
  logic [MS_W-1:0]   cfg_scan = SCAN_TIME_RST;
  logic [MS_W-1:0]   cfg_connect = CONNECT_TIMEOUT_RST;
  logic [MS_W-1:0]   cfg_silence = SILENCE_TIMEOUT_RST;
  logic [MS_W-1:0]   cfg_retry = RETRY_WAIT_RST;

  // Our own copy of the supervisor state.
  mode_t             m_mode = MODE_IDLE;
  logic [CNT_W-1:0]  m_time = '0;
  logic [ADDR_W-1:0] m_blacklist [LIST_DEPTH];
  int                m_fill = 0;
  logic [CNT_W-1:0]  m_attempts = '0;
  logic [CNT_W-1:0]  m_sessions = '0;

  // Reports waiting for their result transaction, oldest first.
  hunt_report_t awaited_reports [$];
  hunt_report_t seen_report;
  hunt_report_t oldest_report;

  int mismatches = 0;
  int requests_sent = 0;
  int results_seen = 0;
  int peak_fill = 0;
  int cmd_tally [4];
  bit flat_out = 1'b0;

  // Random-part state: an address pool, so that blacklist hits and duplicates
  // happen, and the current link episode.
  logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
  int                link_run = 0;
  logic              run_notify = 1'b0;
  logic              run_peer_valid = 1'b0;
  logic [ADDR_W-1:0] run_peer = '0;

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Behavioural supervisor
  // ---------------------------------------------------------------------------

  function automatic void set_mode(mode_t m);
    m_mode = m;
    m_time = '0;
  endfunction

  function automatic logic on_blacklist(logic [ADDR_W-1:0] a);
    for (int i = 0; i < m_fill; i++) begin
      if (m_blacklist[i] == a) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Applies one request to the state copy and returns the report it yields.
  function automatic hunt_report_t supervisor_step(hunt_req_t r);
    hunt_report_t rep;
    logic [CNT_W:0] t;
    rep = '0;
    rep.cmd = CMD_NONE;
    case (r.req)
      REQ_TICK: begin
        // The timer moves first, saturating, whether hunting is on or not.
        t = {1'b0, m_time} + (CNT_W + 1)'(MS_PER_TICK);
        m_time = t[CNT_W] ? '1 : t[CNT_W-1:0];
        if (cfg_auto) begin
          if (r.link_up) begin
            if (m_mode != MODE_LISTEN) set_mode(MODE_LISTEN);
            if (!r.notify_seen && m_time > CNT_W'(cfg_silence)) begin
              // A silent peer is blacklisted once; a full list takes no more.
              if (r.peer_valid && !on_blacklist(r.peer_addr) && m_fill < LIST_DEPTH) begin
                m_blacklist[m_fill] = r.peer_addr;
                m_fill++;
              end
              rep.cmd = CMD_DROP;
              set_mode(MODE_IDLE);
            end
          end else begin
            case (m_mode)
              MODE_IDLE: begin
                if (m_time >= CNT_W'(cfg_retry)) begin
                  // The attempt counts even if the link layer refuses it.
                  m_attempts++;
                  if (cfg_target_valid) begin
                    rep.cmd   = CMD_CONNECT;
                    rep.addr  = cfg_target_addr;
                    rep.ctype = cfg_target_type;
                    if (r.start_ok) set_mode(MODE_CONN);
                  end else begin
                    rep.cmd = CMD_SCAN;
                    if (r.start_ok) set_mode(MODE_SCAN);
                  end
                end
              end
              MODE_SCAN: begin
                if (m_time >= CNT_W'(cfg_scan) + CNT_W'(SCAN_GRACE_MS)) begin
                  if (r.cand_valid) begin
                    rep.cmd   = CMD_CONNECT;
                    rep.addr  = r.cand_addr;
                    rep.ctype = r.cand_type;
                  end
                  set_mode((r.cand_valid && r.start_ok) ? MODE_CONN : MODE_IDLE);
                end
              end
              MODE_CONN: begin
                if (m_time > CNT_W'(cfg_connect)) begin
                  rep.cmd = CMD_DROP;
                  set_mode(MODE_IDLE);
                end
              end
              default: set_mode(MODE_IDLE);
            endcase
          end
        end
      end
      REQ_LOOKUP:  rep.blocked = on_blacklist(r.query_addr);
      REQ_CLEAR:   m_fill = 0;
      default:     m_sessions++;
    endcase
    rep.mode     = m_mode;
    rep.fill     = COUNT_W'(m_fill);
    rep.attempts = m_attempts;
    rep.sessions = m_sessions;
    if (m_fill > peak_fill) peak_fill = m_fill;
    return rep;
  endfunction

  // ---------------------------------------------------------------------------
  // Helpers shared by the tests
  // ---------------------------------------------------------------------------

  function automatic logic [ADDR_W-1:0] rand_addr();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[ADDR_W-1:0];
  endfunction

  function automatic int draw_gap();
    return flat_out ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic hunt_req_t request(req_t q, logic lk, logic nt, logic pv,
                                        logic [ADDR_W-1:0] pa, logic cv,
                                        logic [ADDR_W-1:0] ca, logic [TYPE_W-1:0] ct,
                                        logic so, logic [ADDR_W-1:0] qa);
    hunt_req_t r;
    r.req         = q;
    r.link_up     = lk;
    r.notify_seen = nt;
    r.peer_valid  = pv;
    r.peer_addr   = pa;
    r.cand_valid  = cv;
    r.cand_addr   = ca;
    r.cand_type   = ct;
    r.start_ok    = so;
    r.query_addr  = qa;
    return r;
  endfunction

  // Offers one request after a random gap and holds it until the block takes
  // it. The report is worked out at the edge that accepts the transaction.
  task automatic send_req(hunt_req_t r);
    int gap;
    hunt_report_t rep;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_type    = r.req;
    link_up     = r.link_up;
    notify_seen = r.notify_seen;
    peer_valid  = r.peer_valid;
    peer_addr   = r.peer_addr;
    cand_valid  = r.cand_valid;
    cand_addr   = r.cand_addr;
    cand_type   = r.cand_type;
    start_ok    = r.start_ok;
    query_addr  = r.query_addr;
    in_valid    = 1'b1;
    do @(posedge clk); while (!in_ready);
    rep = supervisor_step(r);
    awaited_reports.push_back(rep);
    cmd_tally[rep.cmd]++;
    requests_sent++;
  endtask

  // Stops offering requests and waits until every result has come back, so
  // that the block is idle and its registers may be written.
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (awaited_reports.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    case (idx)
      CFG_AUTO_ENABLE: begin
        cfg_auto = val[0];
        if (!val[0]) set_mode(MODE_IDLE);
      end
      CFG_TARGET_VALID:    cfg_target_valid = val[0];
      CFG_TARGET_ADDR:     cfg_target_addr  = val[ADDR_W-1:0];
      CFG_TARGET_TYPE:     cfg_target_type  = val[TYPE_W-1:0];
      CFG_SCAN_TIME:       cfg_scan         = val[MS_W-1:0];
      CFG_CONNECT_TIMEOUT: cfg_connect      = val[MS_W-1:0];
      CFG_SILENCE_TIMEOUT: cfg_silence      = val[MS_W-1:0];
      default:             cfg_retry        = val[MS_W-1:0];
    endcase
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Mostly short timeouts so that the modes turn over quickly, sometimes the
  // extremes.
  function automatic logic [CFG_W-1:0] pick_ms();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CFG_W'(MS_MAX);
      2:       return CFG_W'($urandom_range(0, 4000000));
      default: return CFG_W'($urandom_range(0, 6000));
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] pool_or_random(int pool_pct);
    if ($urandom_range(0, 99) < pool_pct) return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
    return rand_addr();
  endfunction

  // One random request. Ticks mostly come in link episodes with a fixed peer
  // and a fixed notification state, which is what lets the silence check and
  // the blacklist fill up; a stray link bit is thrown in now and then.
  function automatic hunt_req_t random_req(int clear_pct);
    hunt_req_t r;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < clear_pct)  r.req = REQ_CLEAR;
    else if (roll < 72)    r.req = REQ_TICK;
    else if (roll < 88)    r.req = REQ_LOOKUP;
    else                   r.req = REQ_SESSION;
    if (link_run == 0 && $urandom_range(0, 6) == 0) begin
      link_run       = $urandom_range(1, 8);
      run_notify     = ($urandom_range(0, 2) == 0);
      run_peer_valid = ($urandom_range(0, 5) != 0);
      run_peer       = pool_or_random(85);
    end
    if (r.req == REQ_TICK && link_run > 0) begin
      link_run--;
      r.link_up     = 1'b1;
      r.notify_seen = run_notify;
      r.peer_valid  = run_peer_valid;
      r.peer_addr   = run_peer;
    end else begin
      r.link_up     = ($urandom_range(0, 19) == 0);
      r.notify_seen = 1'($urandom_range(0, 1));
      r.peer_valid  = 1'($urandom_range(0, 1));
      r.peer_addr   = pool_or_random(50);
    end
    r.cand_valid = ($urandom_range(0, 3) != 0);
    r.cand_addr  = pool_or_random(50);
    r.cand_type  = TYPE_W'($urandom_range(0, 3));
    r.start_ok   = ($urandom_range(0, 3) != 0);
    r.query_addr = pool_or_random(60);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hunting is off after reset: a tick only moves the timer, whatever the
  // link says. Lookups on an empty list miss, and the session counter moves.
  task automatic test_idle_requests();
    send_req(request(REQ_TICK, 1, 1, 1, ADDR_ONES, 1, ADDR_ONES, 2'd3, 1, ADDR_ONES));
    send_req(request(REQ_TICK, 0, 0, 0, '0, 0, '0, 2'd0, 0, '0));
    send_req(request(REQ_LOOKUP, 0, 0, 0, '0, 0, '0, 2'd0, 0, ADDR_ONES));
    send_req(request(REQ_SESSION, 1, 0, 1, ADDR_ONES, 0, '0, 2'd1, 1, '0));
    send_req(request(REQ_CLEAR, 0, 1, 0, '0, 1, ADDR_ONES, 2'd2, 0, ADDR_ONES));
  endtask

  // Zero timeouts, so that every tick is a decision point on the scan path.
  task automatic test_scan_and_connect();
    settle();
    write_reg(CFG_RETRY_WAIT, '0);
    write_reg(CFG_SCAN_TIME, '0);
    write_reg(CFG_CONNECT_TIMEOUT, '0);
    write_reg(CFG_TARGET_VALID, '0);
    write_reg(CFG_AUTO_ENABLE, 1);
    // The link layer refuses the scan: it still counts, the mode stays idle.
    send_req(request(REQ_TICK, 0, 0, 0, '0, 0, '0, 2'd0, 0, '0));
    send_req(request(REQ_TICK, 0, 0, 0, '0, 0, '0, 2'd0, 1, '0));
    // The scan finds nothing: back to idle with no command.
    send_req(request(REQ_TICK, 0, 0, 0, '0, 0, '0, 2'd0, 1, '0));
    send_req(request(REQ_TICK, 0, 0, 0, '0, 0, '0, 2'd0, 1, '0));
    // A candidate, but the connect is refused: the command shows, mode idles.
    send_req(request(REQ_TICK, 0, 0, 0, '0, 1, ADDR_ONES, 2'd3, 0, '0));
    send_req(request(REQ_TICK, 0, 0, 0, '0, 0, '0, 2'd0, 1, '0));
    // A candidate and an accepted connect, which then times out.
    send_req(request(REQ_TICK, 0, 0, 0, '0, 1, '0, 2'd0, 1, '0));
    send_req(request(REQ_TICK, 0, 0, 0, '0, 0, '0, 2'd0, 1, '0));
  endtask

  task automatic test_listen_and_blacklist();
    settle();
    write_reg(CFG_SILENCE_TIMEOUT, '0);
    // A notified link is left alone.
    send_req(request(REQ_TICK, 1, 1, 1, ADDR_ONES, 0, '0, 2'd0, 0, '0));
    // Silent past the timeout: the peer is blacklisted and dropped.
    send_req(request(REQ_TICK, 1, 0, 1, ADDR_ONES, 0, '0, 2'd0, 0, '0));
    // The same peer again: dropped, but the duplicate is not stored.
    send_req(request(REQ_TICK, 1, 0, 1, ADDR_ONES, 0, '0, 2'd0, 0, '0));
    send_req(request(REQ_TICK, 1, 0, 1, ADDR_ONES, 0, '0, 2'd0, 0, '0));
    // A silent peer of unknown address is dropped but not stored.
    send_req(request(REQ_TICK, 1, 0, 0, '0, 0, '0, 2'd0, 0, '0));
    send_req(request(REQ_TICK, 1, 0, 0, '0, 0, '0, 2'd0, 0, '0));
    // Listening when the link has gone: back to idle quietly.
    send_req(request(REQ_TICK, 1, 1, 0, '0, 0, '0, 2'd0, 0, '0));
    send_req(request(REQ_TICK, 0, 0, 0, '0, 0, '0, 2'd0, 0, '0));
    // A hit, a near miss on the lowest bit, then a clear.
    send_req(request(REQ_LOOKUP, 0, 0, 0, '0, 0, '0, 2'd0, 0, ADDR_ONES));
    send_req(request(REQ_LOOKUP, 0, 0, 0, '0, 0, '0, 2'd0, 0, ADDR_ONES - 1));
    send_req(request(REQ_CLEAR, 0, 0, 0, '0, 0, '0, 2'd0, 0, '0));
    send_req(request(REQ_LOOKUP, 0, 0, 0, '0, 0, '0, 2'd0, 0, ADDR_ONES));
  endtask

  // A pinned target skips the scan. The connect timeout sits at its maximum,
  // so the connection attempt just waits. Switching hunting off forces idle.
  task automatic test_pinned_target();
    settle();
    write_reg(CFG_TARGET_ADDR, CFG_W'(rand_addr()));
    write_reg(CFG_TARGET_TYPE, 2);
    write_reg(CFG_CONNECT_TIMEOUT, CFG_W'(MS_MAX));
    write_reg(CFG_TARGET_VALID, 1);
    send_req(request(REQ_TICK, 0, 0, 0, '0, 1, ADDR_ONES, 2'd1, 0, '0));
    send_req(request(REQ_TICK, 0, 0, 0, '0, 1, ADDR_ONES, 2'd1, 1, '0));
    send_req(request(REQ_TICK, 0, 0, 0, '0, 0, '0, 2'd0, 1, '0));
    settle();
    write_reg(CFG_AUTO_ENABLE, 0);
    send_req(request(REQ_TICK, 1, 0, 1, ADDR_ONES, 1, '0, 2'd0, 1, '0));
  endtask

  // Random traffic in phases. Each phase starts from an idle block with a new
  // configuration; halfway through, the sender stops until every result is
  // back. Phase 4 has every timeout at zero, phase 7 every timeout at its
  // maximum, phase 3 runs with hunting off, and phases 2 and 5 run with no
  // idling on either side.
  task automatic test_random_hunt();
    logic [CFG_W-1:0] ms_all;
    int clear_pct;
    addr_pool[0] = ADDR_ONES;
    addr_pool[1] = '0;
    for (int i = 2; i < POOL_SIZE; i++) addr_pool[i] = rand_addr();
    for (int p = 0; p < PHASES; p++) begin
      settle();
      flat_out = (p == 2 || p == 5);
      clear_pct = (p % 3 == 0) ? 0 : 2;
      link_run = 0;
      ms_all = (p == 7) ? CFG_W'(MS_MAX) : '0;
      if (p == 4 || p == 7) begin
        write_reg(CFG_SCAN_TIME, ms_all);
        write_reg(CFG_CONNECT_TIMEOUT, ms_all);
        write_reg(CFG_SILENCE_TIMEOUT, ms_all);
        write_reg(CFG_RETRY_WAIT, ms_all);
      end else begin
        write_reg(CFG_SCAN_TIME, pick_ms());
        write_reg(CFG_CONNECT_TIMEOUT, pick_ms());
        write_reg(CFG_SILENCE_TIMEOUT, pick_ms());
        write_reg(CFG_RETRY_WAIT, pick_ms());
      end
      write_reg(CFG_TARGET_VALID, CFG_W'($urandom_range(0, 1)));
      write_reg(CFG_TARGET_ADDR, CFG_W'(pool_or_random(50)));
      write_reg(CFG_TARGET_TYPE, CFG_W'($urandom_range(0, 3)));
      // Odd phases restart the mode timer by switching hunting off first.
      if (p % 2 == 1) write_reg(CFG_AUTO_ENABLE, 0);
      write_reg(CFG_AUTO_ENABLE, (p == 3) ? 0 : 1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2) settle();
        send_req(random_req(clear_pct));
      end
    end
    flat_out = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // The receiver holds off for a random number of cycles before each result
  // transaction, then takes it as soon as it is offered.
  initial begin
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Each result transaction is matched against the oldest queued report.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      seen_report.cmd      = command;
      seen_report.addr     = conn_addr;
      seen_report.ctype    = conn_type;
      seen_report.mode     = mode_now;
      seen_report.blocked  = is_blocked;
      seen_report.fill     = blocked_count;
      seen_report.attempts = attempt_total;
      seen_report.sessions = session_total;
      results_seen++;
      if (awaited_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result transaction with no request outstanding", $realtime);
      end else begin
        oldest_report = awaited_reports.pop_front();
        if (seen_report !== oldest_report) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result mismatch (expected/actual) cmd %0d/%0d addr %h/%h",
                     $realtime, oldest_report.cmd, seen_report.cmd,
                     oldest_report.addr, seen_report.addr,
                     " type %0d/%0d mode %0d/%0d blocked %b/%b fill %0d/%0d",
                     oldest_report.ctype, seen_report.ctype,
                     oldest_report.mode, seen_report.mode,
                     oldest_report.blocked, seen_report.blocked,
                     oldest_report.fill, seen_report.fill,
                     " attempts %0d/%0d sessions %0d/%0d",
                     oldest_report.attempts, seen_report.attempts,
                     oldest_report.sessions, seen_report.sessions);
        end
      end
    end
  end

  // The watchdog ends the run if no transaction moves on either side for a
  // long stretch; a correct block never stalls anywhere near this long.
  initial begin
    int stalled;
    stalled = 0;
    while (rst) @(posedge clk);
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stalled = 0;
      else stalled++;
    end
    $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
             STALL_LIMIT, awaited_reports.size());
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (7) @(negedge clk);
    rst = 1'b0;
    test_idle_requests();
    test_scan_and_connect();
    test_listen_and_blacklist();
    test_pinned_target();
    test_random_hunt();
    // Let the last results drain, then give the block time to show anything
    // it should not send.
    settle();
    repeat (20) @(posedge clk);
    if (awaited_reports.size() != 0) begin
      $display("%0d results never arrived", awaited_reports.size());
      mismatches += awaited_reports.size();
    end
    $display("%0d requests and %0d results checked; %0d scans, %0d connects, %0d drops",
             requests_sent, results_seen, cmd_tally[CMD_SCAN], cmd_tally[CMD_CONNECT],
             cmd_tally[CMD_DROP]);
    $display("blacklist peaked at %0d of %0d entries over %0d random phases",
             peak_fill, LIST_DEPTH, PHASES);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== link_hunt_supervisor_top.f =====
hdl/lhs_pkg.sv
hdl/lhs_datapath.sv
hdl/lhs_ctrl.sv
hdl/link_hunt_supervisor_top.sv
tb/link_hunt_supervisor_tb.sv
